// ----- rtl/dbpc_pkg.sv -----
// Shared types and constants for the dual button press classifier.
package dbpc_pkg;

  localparam int CFG_W = 16;

  typedef enum logic [0:0] {
    REG_DEBOUNCE_TICKS   = 1'b0,
    REG_LONG_PRESS_TICKS = 1'b1
  } reg_index_t;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_A_SHORT = 3'd1,
    EV_A_LONG  = 3'd2,
    EV_B_SHORT = 3'd3,
    EV_B_LONG  = 3'd4
  } event_t;

  localparam logic [CFG_W-1:0] DEBOUNCE_RESET = 16'd5;
  localparam logic [CFG_W-1:0] LONG_RESET     = 16'd100;

  typedef struct packed {
    logic short_ev;
    logic long_ev;
    logic held;
  } btn_status_t;

endpackage

// ----- rtl/dual_button_press_classifier.sv -----
// Top level: two debounced buttons, pending event latch and result register.
//
//   channel  direction  handshake            payload
//   in       input      in_valid/in_ready    func, raw_a, raw_b
//   out      output     out_valid/out_ready  event_code, a_held, b_held, any_held
//   cfg      input      cfg_write            cfg_index, cfg_data
//
// A new transaction is taken every cycle while the result register is empty or
// being drained, set by the single result register.
// Reset is synchronous: both buttons idle, counters and latch cleared,
// thresholds back to 5 and 100 ticks.
// A stalled result holds in the output register and blocks further input.
module dual_button_press_classifier #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       func,
  input  logic                       raw_a,
  input  logic                       raw_b,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [2:0]                 event_code,
  output logic                       a_held,
  output logic                       b_held,
  output logic                       any_held,
  input  logic                       cfg_write,
  input  logic [0:0]                 cfg_index,
  input  logic [dbpc_pkg::CFG_W-1:0] cfg_data
);
  import dbpc_pkg::*;

  logic [CFG_W-1:0]       debounce_ticks, long_press_ticks;
  logic [COUNT_WIDTH-1:0] settle_limit, hold_limit;
  event_t                 latch, latch_next, res_ev, ev_a, ev_b;
  btn_status_t            st_a, st_b;
  logic                   accept, step;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign step     = accept && !func;

  generate
    if (COUNT_WIDTH >= CFG_W) begin : g_wide
      assign settle_limit = COUNT_WIDTH'(debounce_ticks);
      assign hold_limit   = COUNT_WIDTH'(long_press_ticks);
    end else begin : g_narrow
      localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;
      assign settle_limit = (|debounce_ticks[CFG_W-1:COUNT_WIDTH]) ? CNT_MAX
                            : debounce_ticks[COUNT_WIDTH-1:0];
      assign hold_limit   = (|long_press_ticks[CFG_W-1:COUNT_WIDTH]) ? CNT_MAX
                            : long_press_ticks[COUNT_WIDTH-1:0];
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks   <= DEBOUNCE_RESET;
      long_press_ticks <= LONG_RESET;
    end else if (cfg_write) begin
      case (reg_index_t'(cfg_index))
        REG_DEBOUNCE_TICKS:   debounce_ticks   <= cfg_data;
        REG_LONG_PRESS_TICKS: long_press_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  dbpc_button #(.COUNT_WIDTH(COUNT_WIDTH)) u_btn_a (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .level        (raw_a),
    .settle_limit (settle_limit),
    .hold_limit   (hold_limit),
    .status       (st_a)
  );

  dbpc_button #(.COUNT_WIDTH(COUNT_WIDTH)) u_btn_b (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .level        (raw_b),
    .settle_limit (settle_limit),
    .hold_limit   (hold_limit),
    .status       (st_b)
  );

  always_comb begin
    ev_a = st_a.short_ev ? EV_A_SHORT : (st_a.long_ev ? EV_A_LONG : EV_NONE);
    ev_b = st_b.short_ev ? EV_B_SHORT : (st_b.long_ev ? EV_B_LONG : EV_NONE);
    if (func) begin
      res_ev     = latch;
      latch_next = EV_NONE;
    end else begin
      res_ev = latch;
      if (res_ev == EV_NONE) begin
        res_ev = ev_a;
      end
      if (res_ev == EV_NONE) begin
        res_ev = ev_b;
      end
      latch_next = res_ev;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      latch     <= EV_NONE;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        latch     <= latch_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      event_code <= res_ev;
      a_held     <= st_a.held;
      b_held     <= st_b.held;
      any_held   <= st_a.held | st_b.held;
    end
  end

  a_fetch_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && func) |=> (latch == EV_NONE))
    else $error("latch not cleared after fetch");

  a_latch_keeps: assert property (@(posedge clk) disable iff (rst)
    (latch != EV_NONE && !(accept && func)) |=> (latch == $past(latch)))
    else $error("pending event overwritten");

  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted transaction produced no result");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  a_any_held: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (any_held == (a_held | b_held)))
    else $error("any_held inconsistent with button flags");

endmodule

// ----- rtl/dbpc_button.sv -----
// Per-button debounce and short/long press state machine.
module dbpc_button #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   step,
  input  logic                   level,
  input  logic [COUNT_WIDTH-1:0] settle_limit,
  input  logic [COUNT_WIDTH-1:0] hold_limit,
  output dbpc_pkg::btn_status_t  status
);
  import dbpc_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_DEBOUNCE,
    PH_PRESSED,
    PH_LONG_SENT
  } phase_t;

  phase_t                 phase, phase_next;
  logic [COUNT_WIDTH-1:0] settle, settle_next;
  logic [COUNT_WIDTH-1:0] hold, hold_next;
  logic                   prev;
  logic [COUNT_WIDTH-1:0] settle_bump, hold_bump;
  logic                   short_ev, long_ev;

  assign settle_bump = (settle >= settle_limit) ? settle_limit : settle + 1'b1;
  assign hold_bump   = (hold >= hold_limit) ? hold_limit : hold + 1'b1;

  always_comb begin
    phase_next  = phase;
    settle_next = settle;
    hold_next   = hold;
    short_ev    = 1'b0;
    long_ev     = 1'b0;
    case (phase)
      PH_IDLE: begin
        if (level && !prev) begin
          phase_next  = PH_DEBOUNCE;
          settle_next = '0;
        end
      end
      PH_DEBOUNCE: begin
        settle_next = settle_bump;
        if (!level) begin
          phase_next = PH_IDLE;
        end else if (settle_bump >= settle_limit) begin
          phase_next = PH_PRESSED;
          hold_next  = '0;
        end
      end
      PH_PRESSED: begin
        if (!level) begin
          short_ev   = 1'b1;
          phase_next = PH_IDLE;
        end else begin
          hold_next = hold_bump;
          if (hold_bump >= hold_limit) begin
            long_ev    = 1'b1;
            phase_next = PH_LONG_SENT;
          end
        end
      end
      default: begin
        if (!level) begin
          phase_next = PH_IDLE;
        end
      end
    endcase
  end

  always_comb begin
    status.short_ev = step & short_ev;
    status.long_ev  = step & long_ev;
    if (step) begin
      status.held = (phase_next == PH_PRESSED) || (phase_next == PH_LONG_SENT);
    end else begin
      status.held = (phase == PH_PRESSED) || (phase == PH_LONG_SENT);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_IDLE;
      settle <= '0;
      hold   <= '0;
      prev   <= 1'b0;
    end else if (step) begin
      phase  <= phase_next;
      settle <= settle_next;
      hold   <= hold_next;
      prev   <= level;
    end
  end

endmodule
